[src/kda_pkg.sv]
`timescale 1ns / 1ps

package kda_pkg;

    localparam int KEY_COUNT   = 3;
    localparam int KEY_W       = 3;
    localparam int DREP_W      = 2;
    localparam int PERIOD_W    = 16;
    localparam int DIVIDER_W   = 8;
    localparam int DELAY_W     = 16;
    localparam int HOLD_W      = 16;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((1 << KEY_COUNT) - 1);

    localparam logic [1:0] REG_DEBOUNCE_PERIOD = 2'd0;
    localparam logic [1:0] REG_REPEAT_DIVIDER  = 2'd1;
    localparam logic [1:0] REG_REPEAT_DELAY    = 2'd2;

    localparam logic [PERIOD_W-1:0]  RST_DEBOUNCE_PERIOD = PERIOD_W'(256);
    localparam logic [DIVIDER_W-1:0] RST_REPEAT_DIVIDER  = DIVIDER_W'(10);
    localparam logic [DELAY_W-1:0]   RST_REPEAT_DELAY    = DELAY_W'(5);

    typedef struct packed {
        logic [PERIOD_W-1:0]  debounce_period;
        logic [DIVIDER_W-1:0] repeat_divider;
        logic [DELAY_W-1:0]   repeat_delay;
    } t_cfg;

    typedef struct packed {
        logic [KEY_W-1:0]     sampled_keys;
        logic [KEY_W-1:0]     reference_keys;
        logic [PERIOD_W-1:0]  debounce_count;
        logic [DIVIDER_W-1:0] repeat_phase;
        logic [HOLD_W-1:0]    hold_count;
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]  press_mask;
        logic [KEY_W-1:0]  release_mask;
        logic [KEY_W-1:0]  repeat_mask;
        logic [DREP_W-1:0] delayed_repeat_mask;
    } t_result;

endpackage

[src/kda_regs.sv]
`timescale 1ns / 1ps

module kda_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [kda_pkg::ADDR_W-1:0] paddr,
    input  logic [kda_pkg::DATA_W-1:0] pwdata,
    output logic [kda_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    output kda_pkg::t_cfg             o_cfg
);
    import kda_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_period <= RST_DEBOUNCE_PERIOD;
            r_cfg.repeat_divider  <= RST_REPEAT_DIVIDER;
            r_cfg.repeat_delay    <= RST_REPEAT_DELAY;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_DEBOUNCE_PERIOD: r_cfg.debounce_period <= pwdata[PERIOD_W-1:0];
                REG_REPEAT_DIVIDER:  r_cfg.repeat_divider  <= pwdata[DIVIDER_W-1:0];
                REG_REPEAT_DELAY:    r_cfg.repeat_delay    <= pwdata[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_DEBOUNCE_PERIOD: prdata = DATA_W'(r_cfg.debounce_period);
            REG_REPEAT_DIVIDER:  prdata = DATA_W'(r_cfg.repeat_divider);
            REG_REPEAT_DELAY:    prdata = DATA_W'(r_cfg.repeat_delay);
            default:             prdata = '0;
        endcase
    end

endmodule

[src/kda_qual.sv]
`timescale 1ns / 1ps

module kda_qual (
    input  logic [kda_pkg::KEY_W-1:0] i_raw_keys,
    input  kda_pkg::t_cfg             i_cfg,
    input  kda_pkg::t_state           i_state,
    output kda_pkg::t_state           o_state,
    output kda_pkg::t_result          o_result
);
    import kda_pkg::*;

    logic [KEY_W-1:0]     now_keys;
    logic [PERIOD_W-1:0]  cnt_inc;
    logic                 fire;
    logic [DIVIDER_W-1:0] phase_inc;

    assign now_keys  = ~i_raw_keys & KEY_MASK;
    assign cnt_inc   = i_state.debounce_count + PERIOD_W'(1);
    // wrapped counter also fires, so a zero period acts like one
    assign fire      = (cnt_inc >= i_cfg.debounce_period) || (cnt_inc == '0);
    assign phase_inc = i_state.repeat_phase + DIVIDER_W'(1);

    always_comb begin
        o_state              = i_state;
        o_result             = '0;
        o_state.sampled_keys = now_keys;
        if (now_keys != i_state.sampled_keys) begin
            o_state.debounce_count = '0;
            o_state.reference_keys = i_state.sampled_keys;
        end else if (fire) begin
            o_state.debounce_count = '0;
            o_result.press_mask    = now_keys & ~i_state.reference_keys;
            o_result.release_mask  = ~now_keys & i_state.reference_keys;
            o_state.repeat_phase   = phase_inc;
            if (phase_inc == i_cfg.repeat_divider) begin
                o_state.repeat_phase = '0;
                o_result.repeat_mask = now_keys;
                if (i_state.hold_count >= i_cfg.repeat_delay) begin
                    o_result.delayed_repeat_mask = now_keys[2:1];
                end
                if (i_state.hold_count != '1) begin
                    o_state.hold_count = i_state.hold_count + HOLD_W'(1);
                end
            end
            if (now_keys == '0) begin
                o_state.hold_count = '0;
            end
            o_state.reference_keys = now_keys;
        end else begin
            o_state.debounce_count = cnt_inc;
        end
    end

endmodule

[src/key_debounce_autorepeat_core.sv]
`timescale 1ns / 1ps
// Each accepted word's result word is registered in the output register.
// Throughput: one word per clock; the single output register is refilled in the
// same cycle it is taken, so input ready follows output ready.
// Reset (synchronous, active low): no key down, timers cleared, registers to
// period 256, divider 10, delay 5.

module key_debounce_autorepeat_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [kda_pkg::KEY_W-1:0]  i_raw_keys,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [kda_pkg::KEY_W-1:0]  o_press_mask,
    output logic [kda_pkg::KEY_W-1:0]  o_release_mask,
    output logic [kda_pkg::KEY_W-1:0]  o_repeat_mask,
    output logic [kda_pkg::DREP_W-1:0] o_delayed_repeat_mask,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [kda_pkg::ADDR_W-1:0] paddr,
    input  logic [kda_pkg::DATA_W-1:0] pwdata,
    output logic [kda_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import kda_pkg::*;

    t_cfg    cfg;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_result;
    logic    r_out_valid;
    logic    accept;

    kda_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    kda_qual u_qual (
        .i_raw_keys (i_raw_keys),
        .i_cfg      (cfg),
        .i_state    (r_state),
        .o_state    (n_state),
        .o_result   (n_result)
    );

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state <= n_state;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_press_mask          = r_result.press_mask;
    assign o_release_mask        = r_result.release_mask;
    assign o_repeat_mask         = r_result.repeat_mask;
    assign o_delayed_repeat_mask = r_result.delayed_repeat_mask;

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import kda_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_CAP   = 20;
    // unmapped register slot, writes to it must not disturb anything
    localparam logic [1:0] REG_SPARE = 2'd3;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [KEY_W-1:0]   i_raw_keys;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [KEY_W-1:0]   o_press_mask;
    logic [KEY_W-1:0]   o_release_mask;
    logic [KEY_W-1:0]   o_repeat_mask;
    logic [DREP_W-1:0]  o_delayed_repeat_mask;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    key_debounce_autorepeat_core DUT (.*);

    // debouncer model state
    t_cfg               cfg_model;
    logic [KEY_W-1:0]   keys_down;
    logic [KEY_W-1:0]   keys_ref;
    logic [PERIOD_W-1:0]  stable_ticks;
    logic [DIVIDER_W-1:0] step_phase;
    logic [HOLD_W-1:0]    hold_steps;

    logic [KEY_W-1:0]   scan_queue[$];
    t_result            pending_results[$];

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  word_taken;
    int  mismatches;
    int  cycle_count;
    int  scans_taken;
    int  edge_words;
    int  repeat_words;
    int  delayed_words;
    int  reg_writes;
    int  cfg_settings;

    t_result scan_result;
    t_result got_result;
    t_result want_result;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t: mismatch: %s", $time, what);
    endtask

    // one scan tick of the debouncer
    task automatic debounce_scan(input logic [KEY_W-1:0] raw, output t_result res);
        logic [KEY_W-1:0] now;
        now = ~raw & KEY_MASK;
        res = '0;
        if (now != keys_down) begin
            stable_ticks = '0;
            keys_ref = keys_down;
        end else begin
            stable_ticks = stable_ticks + 1'b1;
            // zero period: the wrap to zero also qualifies
            if (stable_ticks >= cfg_model.debounce_period || stable_ticks == '0) begin
                stable_ticks = '0;
                res.press_mask   = now & ~keys_ref;
                res.release_mask = ~now & keys_ref;
                step_phase = step_phase + 1'b1;
                if (step_phase == cfg_model.repeat_divider) begin
                    step_phase = '0;
                    res.repeat_mask = now;
                    if (hold_steps >= cfg_model.repeat_delay)
                        res.delayed_repeat_mask = now[2:1];
                    if (hold_steps != '1)
                        hold_steps = hold_steps + 1'b1;
                end
                if (now == '0)
                    hold_steps = '0;
                keys_ref = now;
            end
        end
        keys_down = now;
    endtask

    function automatic logic [DATA_W-1:0] field_mask(input logic [1:0] idx);
        case (idx)
            REG_DEBOUNCE_PERIOD: return DATA_W'({PERIOD_W{1'b1}});
            REG_REPEAT_DIVIDER:  return DATA_W'({DIVIDER_W{1'b1}});
            REG_REPEAT_DELAY:    return DATA_W'({DELAY_W{1'b1}});
            default:             return '0;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] cfg_field(input logic [1:0] idx);
        case (idx)
            REG_DEBOUNCE_PERIOD: return DATA_W'(cfg_model.debounce_period);
            REG_REPEAT_DIVIDER:  return DATA_W'(cfg_model.repeat_divider);
            REG_REPEAT_DELAY:    return DATA_W'(cfg_model.repeat_delay);
            default:             return '0;
        endcase
    endfunction

    function automatic bit busy();
        return scan_queue.size() != 0 || i_in_valid || pending_results.size() != 0;
    endfunction

    // upper bits get random junk, the block must keep only the field
    task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] data;
        data = value | ($urandom() & ~field_mask(idx));
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DEBOUNCE_PERIOD: cfg_model.debounce_period = data[PERIOD_W-1:0];
            REG_REPEAT_DIVIDER:  cfg_model.repeat_divider  = data[DIVIDER_W-1:0];
            REG_REPEAT_DELAY:    cfg_model.repeat_delay    = data[DELAY_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic reg_check(input logic [1:0] idx);
        logic [DATA_W-1:0] seen;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        seen = prdata & field_mask(idx);
        if (seen !== cfg_field(idx))
            report_mismatch($sformatf("register %0d reads %h, expected %h",
                                      idx, seen, cfg_field(idx)));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk); while (busy());
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(input int p_period, input int p_div, input int p_delay);
        wait_idle();
        reg_write(REG_DEBOUNCE_PERIOD, DATA_W'(p_period));
        reg_write(REG_REPEAT_DIVIDER, DATA_W'(p_div));
        reg_write(REG_REPEAT_DELAY, DATA_W'(p_delay));
        reg_check(REG_DEBOUNCE_PERIOD);
        reg_check(REG_REPEAT_DIVIDER);
        reg_check(REG_REPEAT_DELAY);
        cfg_settings++;
    endtask

    task automatic queue_run(input logic [KEY_W-1:0] raw, input int len);
        repeat (len) scan_queue.push_back(raw);
    endtask

    // mostly held patterns of random length, some contact bounce in between
    task automatic queue_random_scans(input int count, input int max_run);
        int added;
        int len;
        logic [KEY_W-1:0] raw;
        added = 0;
        while (added < count) begin
            if ($urandom_range(99) < 20) begin
                len = $urandom_range(1, 3);
                repeat (len) scan_queue.push_back(KEY_W'($urandom_range(7)));
            end else begin
                raw = ($urandom_range(99) < 15) ? '1 : KEY_W'($urandom_range(6));
                len = $urandom_range(1, max_run);
                queue_run(raw, len);
            end
            added += len;
        end
    endtask

    // sender and receiver idling, inputs move on the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || word_taken) begin
                if (scan_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_raw_keys <= scan_queue.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        word_taken = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got_result.press_mask          = o_press_mask;
                got_result.release_mask        = o_release_mask;
                got_result.repeat_mask         = o_repeat_mask;
                got_result.delayed_repeat_mask = o_delayed_repeat_mask;
                if (pending_results.size() == 0) begin
                    report_mismatch("result word with no scan word pending");
                end else begin
                    want_result = pending_results.pop_front();
                    if (got_result !== want_result)
                        report_mismatch($sformatf(
                            "press %b/%b release %b/%b repeat %b/%b delayed %b/%b (got/exp)",
                            got_result.press_mask, want_result.press_mask,
                            got_result.release_mask, want_result.release_mask,
                            got_result.repeat_mask, want_result.repeat_mask,
                            got_result.delayed_repeat_mask,
                            want_result.delayed_repeat_mask));
                end
            end
            if (i_in_valid && o_in_ready) begin
                debounce_scan(i_raw_keys, scan_result);
                pending_results.push_back(scan_result);
                word_taken = 1'b1;
                scans_taken++;
                if (|scan_result.press_mask || |scan_result.release_mask)
                    edge_words++;
                if (|scan_result.repeat_mask)
                    repeat_words++;
                if (|scan_result.delayed_repeat_mask)
                    delayed_words++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_raw_keys  = '1;
        i_out_ready = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        cfg_model.debounce_period = RST_DEBOUNCE_PERIOD;
        cfg_model.repeat_divider  = RST_REPEAT_DIVIDER;
        cfg_model.repeat_delay    = RST_REPEAT_DELAY;
        keys_down    = '0;
        keys_ref     = '0;
        stable_ticks = '0;
        step_phase   = '0;
        hold_steps   = '0;
        send_idle_pct = 20;
        recv_idle_pct = 68;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        reg_check(REG_DEBOUNCE_PERIOD);
        reg_check(REG_REPEAT_DIVIDER);
        reg_check(REG_REPEAT_DELAY);

        // reset settings: long period, nothing qualifies
        queue_run(3'b111, 1);
        queue_run(3'b000, 2);
        queue_run(3'b101, 1);

        // zero period acts as one, every step repeats, delayed repeats at once
        configure(0, 1, 0);
        reg_write(REG_SPARE, '0);
        queue_run(3'b101, 1);
        queue_run(3'b000, 3);
        queue_run(3'b110, 2);
        queue_run(3'b011, 2);
        queue_run(3'b111, 3);
        queue_run(3'b010, 2);

        configure(1, 2, 3);
        queue_random_scans(170, 8);
        configure(3, 1, 0);
        queue_random_scans(170, 16);
        configure(0, 255, 1);
        queue_random_scans(300, 12);

        send_idle_pct = 68;
        recv_idle_pct = 20;
        // divider now very likely below the running phase, which has to wrap
        configure(1, 3, 2);
        queue_random_scans(280, 10);
        // build up a long stable count, then drop the period under it
        configure(200, 4, 65535);
        queue_run(3'b010, 60);
        configure(20, 4, 65535);
        queue_run(3'b010, 4);
        queue_random_scans(150, 60);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure(65535, 0, 0);
        queue_random_scans(40, 20);
        // zero divider: repeat only after 256 steps
        configure(0, 0, 4);
        queue_random_scans(250, 12);

        wait_idle();
        $display("Ran %0d key scan words through %0d register settings (%0d writes).",
                 scans_taken, cfg_settings, reg_writes);
        $display("Words with edges: %0d, with repeats: %0d, with delayed repeats: %0d.",
                 edge_words, repeat_words, delayed_words);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches in total", mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[files.f]
src/kda_pkg.sv
src/kda_regs.sv
src/kda_qual.sv
src/key_debounce_autorepeat_core.sv
test/tb_top.sv
